// ----- sv/sorted_range_set_insert_merge_unit_defines.svh -----
// Assertion macros shared by the sorted range set RTL.
`ifndef SORTED_RANGE_SET_INSERT_MERGE_UNIT_DEFINES_SVH
`define SORTED_RANGE_SET_INSERT_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSIM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSIM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srsim_pkg.sv -----
// Shared constants and types for the sorted range set unit.
package srsim_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int FIELD_BITS = 16;
    localparam int INDEX_BITS = 4;
    localparam int COUNT_BITS = 5;

    typedef enum logic [0:0] {
        FN_INSERT = 1'b0,
        FN_READ   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE_WR,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ----- sv/srsim_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srsim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/sorted_range_set_insert_merge_unit.sv -----
// Sorted range set: inserts a range, merges it with its neighbors, reads entries back.
//
// Input channel (i_in_valid / o_in_stall): one transfer carries func, range_start,
// range_end and read_index. Output channel (o_out_valid / i_out_stall): one result
// per input item with entry_start, entry_end, range_count and status.
// The table is kept in a RAM with two banks. An insert walks the n stored ranges of
// the active bank once, one RAM read and one compare/merge step per cycle, writing
// the compacted table into the other bank; the banks swap unless the table would
// overflow, in which case the insert is dropped with a full status.
// An insert walks at most TABLE_DEPTH stored ranges; a bad range or index goes
// straight to the result with no scan or read step.
// The rate is set by the single RAM read port, which delivers one stored range a
// cycle; the next item can be taken in the cycle after the result is loaded.
// The result register frees the sequencer: a new item is taken while the previous
// result waits. A result is only loaded when the register is empty or being taken,
// so a stalled receiver holds the result stable and eventually stalls the input.
// Reset (synchronous, active low) empties the table and the result register; the
// RAM contents need no clearing since only entries below the count are read.
`include "sorted_range_set_insert_merge_unit_defines.svh"

module sorted_range_set_insert_merge_unit #(
    parameter int TABLE_DEPTH = srsim_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = srsim_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [srsim_pkg::FIELD_BITS-1:0]  i_range_start,
    input  logic [srsim_pkg::FIELD_BITS-1:0]  i_range_end,
    input  logic [srsim_pkg::INDEX_BITS-1:0]  i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [srsim_pkg::FIELD_BITS-1:0]  o_entry_start,
    output logic [srsim_pkg::FIELD_BITS-1:0]  o_entry_end,
    output logic [srsim_pkg::COUNT_BITS-1:0]  o_range_count,
    output srsim_pkg::t_status                o_status
);
    import srsim_pkg::*;

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CNW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = CNW + 1;
    localparam int CMPW = (CNW > INDEX_BITS) ? CNW : INDEX_BITS;
    localparam int VW   = VALUE_BITS;
    localparam int XW   = VALUE_BITS + 1;
    // Each bank spans the full index space so {bank, index} stays in range.
    localparam int TBL_WORDS = 2 * (1 << IW);

    t_state         r_state, n_state;
    logic           r_bank;
    logic [CNW-1:0] r_count;
    logic [IW-1:0]  r_idx;
    logic [CNW-1:0] r_nb;
    logic [CNW-1:0] r_na;
    logic [VW-1:0]  r_ns;
    logic [VW-1:0]  r_ne;
    logic [VW-1:0]  r_res_s;
    logic [VW-1:0]  r_res_e;
    t_status        r_res_st;

    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_out_s;
    logic [FIELD_BITS-1:0] r_out_e;
    logic [COUNT_BITS-1:0] r_out_cnt;
    t_status               r_out_st;

    logic [VW-1:0]   w_in_s;
    logic [VW-1:0]   w_in_e;
    logic            w_take;
    logic            w_out_free;
    logic            w_idx_ok;
    logic            w_order_bad;
    logic [2*VW-1:0] w_rd_data;
    logic [VW-1:0]   w_os;
    logic [VW-1:0]   w_oe;
    logic            w_before;
    logic            w_after;
    logic            w_last;
    logic [SW-1:0]   w_slot;
    logic            w_full;

    logic            w_wr_en;
    logic [IW-1:0]   w_wr_idx;
    logic [2*VW-1:0] w_wr_data;
    logic [IW-1:0]   w_rd_idx;

    // Cut incoming bounds to the stored value width.
    assign w_in_s = VW'(i_range_start);
    assign w_in_e = VW'(i_range_end);

    assign w_take      = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_idx_ok    = CMPW'(i_read_index) < CMPW'(r_count);
    assign w_order_bad = w_in_s > w_in_e;

    assign w_os = w_rd_data[2*VW-1:VW];
    assign w_oe = w_rd_data[VW-1:0];

    // Shared compare unit: classify the stored range against the growing merged range.
    assign w_before = ({1'b0, w_oe} + XW'(1)) < {1'b0, r_ns};
    assign w_after  = {1'b0, w_os} > ({1'b0, r_ne} + XW'(1));
    assign w_last   = (CNW'(r_idx) + CNW'(1)) == r_count;
    assign w_slot   = SW'(r_nb) + SW'(1) + SW'(r_na);
    assign w_full   = w_slot > SW'(TABLE_DEPTH);

    srsim_ram #(
        .WIDTH (2 * VW),
        .DEPTH (TBL_WORDS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr ({~r_bank, w_wr_idx}),
        .i_wr_data (w_wr_data),
        .i_rd_addr ({r_bank, w_rd_idx}),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_func == FN_READ) begin
                        n_state = w_idx_ok ? S_READ : S_DONE;
                    end else if (w_order_bad) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_MERGE_WR;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_MERGE_WR;
                end
            end
            S_MERGE_WR: n_state = S_DONE;
            S_READ:     n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_wr_en    = 1'b0;
        w_wr_idx   = IW'(r_nb);
        w_wr_data  = w_rd_data;
        // Read one entry ahead of the one being compared.
        w_rd_idx   = r_idx + IW'(1);
        unique case (r_state)
            S_IDLE: begin
                w_rd_idx = (i_func == FN_READ) ? IW'(i_read_index) : '0;
            end
            S_SCAN: begin
                if (w_before) begin
                    w_wr_en = 1'b1;
                end else if (w_after) begin
                    // Drop writes past the end; the insert is flagged full anyway.
                    w_wr_en  = w_slot < SW'(TABLE_DEPTH);
                    w_wr_idx = IW'(w_slot);
                end
            end
            S_MERGE_WR: begin
                w_wr_en   = !w_full;
                w_wr_data = {r_ns, r_ne};
            end
            S_READ, S_DONE: begin
                w_wr_en = 1'b0;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MERGE_WR && !w_full) begin
                r_bank  <= ~r_bank;
                r_count <= CNW'(w_slot);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    r_ns    <= w_in_s;
                    r_ne    <= w_in_e;
                    r_idx   <= '0;
                    r_nb    <= '0;
                    r_na    <= '0;
                    r_res_s <= '0;
                    r_res_e <= '0;
                    if (i_func == FN_READ) begin
                        r_res_st <= w_idx_ok ? ST_OK : ST_INDEX;
                    end else begin
                        r_res_st <= w_order_bad ? ST_ORDER : ST_OK;
                    end
                end
            end
            S_SCAN: begin
                r_idx <= r_idx + IW'(1);
                if (w_before) begin
                    r_nb <= r_nb + CNW'(1);
                end else if (w_after) begin
                    r_na <= r_na + CNW'(1);
                end else begin
                    // Absorb the overlapping or touching range.
                    if (w_os < r_ns) begin
                        r_ns <= w_os;
                    end
                    if (w_oe > r_ne) begin
                        r_ne <= w_oe;
                    end
                end
            end
            S_MERGE_WR: begin
                if (w_full) begin
                    r_res_st <= ST_FULL;
                end else begin
                    r_res_s <= r_ns;
                    r_res_e <= r_ne;
                end
            end
            S_READ: begin
                r_res_s <= w_os;
                r_res_e <= w_oe;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_s   <= FIELD_BITS'(r_res_s);
                    r_out_e   <= FIELD_BITS'(r_res_e);
                    r_out_cnt <= COUNT_BITS'(r_count);
                    r_out_st  <= r_res_st;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_start = r_out_s;
    assign o_entry_end   = r_out_e;
    assign o_range_count = r_out_cnt;
    assign o_status      = r_out_st;

    `SRSIM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNW'(TABLE_DEPTH), "stored count exceeds table depth")
    `SRSIM_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), (o_entry_start == '0) && (o_entry_end == '0), "error result carries a nonzero range")
    `SRSIM_ASSERT_IMP(a_bank_swap, i_clk, i_rst_n, $past(i_rst_n) && (r_bank != $past(r_bank)), $past(r_state) == S_MERGE_WR, "bank swapped outside merge write")
    `SRSIM_ASSERT_NXT(a_take_busy, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state != S_IDLE, "sequencer stayed idle after a transfer")

endmodule
